/* design/ldpm_pkg.sv */
`default_nettype none

package ldpm_pkg;

  // Fixed-point formats
  localparam int unsigned PixW    = 16;             // Q12.4 pixel coordinate
  localparam int unsigned QW      = 32;             // Q2.30 intermediate / Q8.24 coefficient
  localparam int unsigned WideW   = 66;             // headroom for sums before saturation
  localparam int unsigned CoefSh  = 24;             // Q8.24 * Q2.30 -> Q2.30
  localparam int unsigned QSh     = 30;             // Q2.30 * Q2.30 -> Q2.30

  // Divider layout: one quotient bit per step
  localparam int unsigned QuoW          = 32;
  localparam int unsigned StepsPerStage = 8;
  localparam int unsigned DivStages     = QuoW / StepsPerStage;

  // Full pipeline depth, from input register to output register
  localparam int unsigned NumStages = 18;

  localparam logic signed [QW-1:0] Q30Max = 32'sh7fff_ffff;
  localparam logic signed [QW-1:0] Q30Min = 32'sh8000_0000;
  localparam logic signed [WideW-1:0] Q30One = 66'sh0_4000_0000;

  // Register reset values
  localparam logic [31:0]      PrincipalRst = 32'h0000_0000;
  localparam logic [PixW-1:0]  FocalRst     = 16'd16;

  // Register map
  typedef enum logic [2:0] {
    RegPrincipal = 3'd0,
    RegFocalX    = 3'd1,
    RegFocalY    = 3'd2,
    RegK1        = 3'd3,
    RegK2        = 3'd4,
    RegK3        = 3'd5,
    RegP1        = 3'd6,
    RegP2        = 3'd7
  } ldpm_reg_e;

  // One divider word in flight
  typedef struct packed {
    logic [PixW-1:0] rem;
    logic [QuoW-1:0] quo;
    logic [1:0]      low;   // low dividend bits still to bring down
    logic            neg;
    logic            ovf;
  } ldpm_div_t;

  // Clamp a wide signed value to Q2.30 range
  function automatic logic signed [QW-1:0] sat_q30(input logic signed [WideW-1:0] v);
    logic signed [QW-1:0] r;
    if (v > WideW'(Q30Max)) begin
      r = Q30Max;
    end else if (v < WideW'(Q30Min)) begin
      r = Q30Min;
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

  // One restoring division step, j counts from the quotient MSB
  function automatic ldpm_div_t div_step(input ldpm_div_t w, input logic [PixW-1:0] den,
                                         input int unsigned j);
    ldpm_div_t   r;
    logic        bit_in;
    logic [PixW:0] part;
    r      = w;
    bit_in = (j == 0) ? w.low[1] : ((j == 1) ? w.low[0] : 1'b0);
    part   = {w.rem, bit_in};
    if (part >= {1'b0, den}) begin
      r.rem = PixW'(part - {1'b0, den});
      r.quo[5'(QuoW - 1 - j)] = 1'b1;
    end else begin
      r.rem = part[PixW-1:0];
    end
    return r;
  endfunction

  // Turn a finished quotient magnitude into a saturated Q2.30 value
  function automatic logic signed [QW-1:0] quo_to_q30(input ldpm_div_t w);
    logic signed [QW-1:0] r;
    if (w.ovf || w.quo[QuoW-1]) begin
      r = w.neg ? Q30Min : Q30Max;
    end else if (w.neg) begin
      r = -$signed(w.quo);
    end else begin
      r = $signed(w.quo);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/ldpm_divider.sv */
`default_nettype none

module ldpm_divider (
  input  wire logic                                   clk_i,
  input  wire logic [ldpm_pkg::DivStages-1:0]         adv_i,
  input  wire logic [ldpm_pkg::PixW-1:0]              den_i,
  input  wire ldpm_pkg::ldpm_div_t                    word_i,
  output ldpm_pkg::ldpm_div_t                         word_o
);

  ldpm_pkg::ldpm_div_t pipe [ldpm_pkg::DivStages+1];

  assign pipe[0] = word_i;

  // Each stage resolves a fixed group of quotient bits
  for (genvar s = 0; s < ldpm_pkg::DivStages; s++) begin : g_stage
    ldpm_pkg::ldpm_div_t nxt;

    always_comb begin
      nxt = pipe[s];
      for (int unsigned i = 0; i < ldpm_pkg::StepsPerStage; i++) begin
        nxt = ldpm_pkg::div_step(nxt, den_i, s * ldpm_pkg::StepsPerStage + i);
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i[s]) begin
        pipe[s+1] <= nxt;
      end
    end
  end

  assign word_o = pipe[ldpm_pkg::DivStages];

endmodule

`default_nettype wire

/* design/lens_distortion_point_map.sv */
`default_nettype none

// Brown-Conrady lens distortion (k1, k2, k3, p1, p2) of image points in Q12.4 pixels.
// One point is taken every clock while s_axis_tready is high; the pipeline depth is
// set by the 32-bit restoring divider for the focal normalization (four stages of
// eight quotient bits) followed by the chain of 32-bit products r2, r4, r6, radial
// factor and scale-back, each with a register behind it. Every stage has its own
// valid bit and advances when the stage after it can take its word, so a stall at
// the output fills empty stages first and drops or repeats nothing. Coefficients are
// read straight from the registers, so write them only while no point is in flight.
module lens_distortion_point_map (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  // point stream in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // point_x[15:0], point_y[31:16]
  // mapped point stream out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // mapped_x[15:0], mapped_y[31:16]
  output logic             m_axis_tuser    // clipped[0]
);

  localparam int unsigned Last = ldpm_pkg::NumStages - 1;

  // ---------------------------------------------------------------- config
  logic [31:0]        pp_q;
  logic [15:0]        fx_q, fy_q;
  logic signed [31:0] k1_q, k2_q, k3_q, p1_q, p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_q <= ldpm_pkg::PrincipalRst;
      fx_q <= ldpm_pkg::FocalRst;
      fy_q <= ldpm_pkg::FocalRst;
      k1_q <= '0;
      k2_q <= '0;
      k3_q <= '0;
      p1_q <= '0;
      p2_q <= '0;
    end else if (cfg_we_i) begin
      unique case (ldpm_pkg::ldpm_reg_e'(cfg_index_i))
        ldpm_pkg::RegPrincipal: pp_q <= cfg_data_i;
        ldpm_pkg::RegFocalX:    fx_q <= cfg_data_i[15:0];
        ldpm_pkg::RegFocalY:    fy_q <= cfg_data_i[15:0];
        ldpm_pkg::RegK1:        k1_q <= cfg_data_i;
        ldpm_pkg::RegK2:        k2_q <= cfg_data_i;
        ldpm_pkg::RegK3:        k3_q <= cfg_data_i;
        ldpm_pkg::RegP1:        p1_q <= cfg_data_i;
        ldpm_pkg::RegP2:        p2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [15:0] cx, cy, fx, fy;
  assign cx = pp_q[31:16];
  assign cy = pp_q[15:0];
  // treat a zero focal length as one LSB
  assign fx = (fx_q == '0) ? 16'd1 : fx_q;
  assign fy = (fy_q == '0) ? 16'd1 : fy_q;

  // ---------------------------------------------------------------- flow control
  logic [ldpm_pkg::NumStages-1:0] vld_q, vld_d, adv;

  always_comb begin
    adv[Last] = !vld_q[Last] || m_axis_tready;
    for (int k = Last - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < ldpm_pkg::NumStages; k++) begin
      if (adv[k]) begin
        vld_d[k] = (k == 0) ? s_axis_tvalid : vld_q[(k == 0) ? 0 : k - 1];
      end else begin
        vld_d[k] = vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = adv[0];

  // ---------------------------------------------------------------- stage 0: offset
  logic [15:0]        px, py, ax, ay;
  logic signed [16:0] dx, dy;
  ldpm_pkg::ldpm_div_t s0x_d, s0y_d, s0x_q, s0y_q;

  assign px = s_axis_tdata[15:0];
  assign py = s_axis_tdata[31:16];

  always_comb begin
    dx = $signed({1'b0, px}) - $signed({1'b0, cx});
    dy = $signed({1'b0, py}) - $signed({1'b0, cy});
    ax = dx[16] ? 16'(-dx) : dx[15:0];
    ay = dy[16] ? 16'(-dy) : dy[15:0];
    s0x_d.rem = {2'b00, ax[15:2]};
    s0x_d.quo = '0;
    s0x_d.low = ax[1:0];
    s0x_d.neg = dx[16];
    s0x_d.ovf = ({2'b00, ax} >= {fx, 2'b00});
    s0y_d.rem = {2'b00, ay[15:2]};
    s0y_d.quo = '0;
    s0y_d.low = ay[1:0];
    s0y_d.neg = dy[16];
    s0y_d.ovf = ({2'b00, ay} >= {fy, 2'b00});
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s0x_q <= s0x_d;
      s0y_q <= s0y_d;
    end
  end

  // ---------------------------------------------------------------- stages 1-4: divide
  ldpm_pkg::ldpm_div_t qx, qy;

  ldpm_divider u_div_x (
    .clk_i  (clk_i),
    .adv_i  (adv[ldpm_pkg::DivStages:1]),
    .den_i  (fx),
    .word_i (s0x_q),
    .word_o (qx)
  );

  ldpm_divider u_div_y (
    .clk_i  (clk_i),
    .adv_i  (adv[ldpm_pkg::DivStages:1]),
    .den_i  (fy),
    .word_i (s0y_q),
    .word_o (qy)
  );

  // ---------------------------------------------------------------- stage 5: normalized x, y
  logic signed [31:0] s5_x_q, s5_y_q;

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      s5_x_q <= ldpm_pkg::quo_to_q30(qx);
      s5_y_q <= ldpm_pkg::quo_to_q30(qy);
    end
  end

  // ---------------------------------------------------------------- stage 6: squares
  logic signed [63:0] s6_xx_q, s6_yy_q, s6_xy_q;
  logic signed [31:0] s6_x_q, s6_y_q;

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      s6_xx_q <= s5_x_q * s5_x_q;
      s6_yy_q <= s5_y_q * s5_y_q;
      s6_xy_q <= s5_x_q * s5_y_q;
      s6_x_q  <= s5_x_q;
      s6_y_q  <= s5_y_q;
    end
  end

  // ---------------------------------------------------------------- stage 7: r2 and tangential sums
  logic signed [33:0] sh_xx, sh_yy, sh_xy;
  logic signed [31:0] x2, y2, r2_d;
  logic signed [31:0] s7_x_q, s7_y_q, s7_r2_q, s7_xy_q, s7_tx_q, s7_ty_q;

  assign sh_xx = s6_xx_q[63:30];
  assign sh_yy = s6_yy_q[63:30];
  assign sh_xy = s6_xy_q[63:30];
  assign x2    = ldpm_pkg::sat_q30(66'(sh_xx));
  assign y2    = ldpm_pkg::sat_q30(66'(sh_yy));
  assign r2_d  = ldpm_pkg::sat_q30(66'(x2) + 66'(y2));

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      s7_x_q  <= s6_x_q;
      s7_y_q  <= s6_y_q;
      s7_xy_q <= ldpm_pkg::sat_q30(66'(sh_xy));
      s7_r2_q <= r2_d;
      s7_tx_q <= ldpm_pkg::sat_q30(66'(r2_d) + (66'(x2) <<< 1));
      s7_ty_q <= ldpm_pkg::sat_q30(66'(r2_d) + (66'(y2) <<< 1));
    end
  end

  // ---------------------------------------------------------------- stage 8: r2^2, k1 term
  logic signed [63:0] k1r2_p;
  logic signed [63:0] s8_rr_q;
  logic signed [39:0] s8_k1t_q;
  logic signed [31:0] s8_x_q, s8_y_q, s8_r2_q, s8_xy_q, s8_tx_q, s8_ty_q;

  assign k1r2_p = k1_q * s7_r2_q;

  always_ff @(posedge clk_i) begin
    if (adv[8]) begin
      s8_rr_q  <= s7_r2_q * s7_r2_q;
      s8_k1t_q <= k1r2_p[63:24];
      s8_x_q   <= s7_x_q;
      s8_y_q   <= s7_y_q;
      s8_r2_q  <= s7_r2_q;
      s8_xy_q  <= s7_xy_q;
      s8_tx_q  <= s7_tx_q;
      s8_ty_q  <= s7_ty_q;
    end
  end

  // ---------------------------------------------------------------- stage 9: r4
  logic signed [33:0] sh_rr;
  logic signed [31:0] s9_r4_q;
  logic signed [39:0] s9_k1t_q;
  logic signed [31:0] s9_x_q, s9_y_q, s9_r2_q, s9_xy_q, s9_tx_q, s9_ty_q;

  assign sh_rr = s8_rr_q[63:30];

  always_ff @(posedge clk_i) begin
    if (adv[9]) begin
      s9_r4_q  <= ldpm_pkg::sat_q30(66'(sh_rr));
      s9_k1t_q <= s8_k1t_q;
      s9_x_q   <= s8_x_q;
      s9_y_q   <= s8_y_q;
      s9_r2_q  <= s8_r2_q;
      s9_xy_q  <= s8_xy_q;
      s9_tx_q  <= s8_tx_q;
      s9_ty_q  <= s8_ty_q;
    end
  end

  // ---------------------------------------------------------------- stage 10: r4*r2, k2 term
  logic signed [63:0] k2r4_p;
  logic signed [63:0] s10_r6p_q;
  logic signed [39:0] s10_k1t_q, s10_k2t_q;
  logic signed [31:0] s10_x_q, s10_y_q, s10_xy_q, s10_tx_q, s10_ty_q;

  assign k2r4_p = k2_q * s9_r4_q;

  always_ff @(posedge clk_i) begin
    if (adv[10]) begin
      s10_r6p_q <= s9_r4_q * s9_r2_q;
      s10_k2t_q <= k2r4_p[63:24];
      s10_k1t_q <= s9_k1t_q;
      s10_x_q   <= s9_x_q;
      s10_y_q   <= s9_y_q;
      s10_xy_q  <= s9_xy_q;
      s10_tx_q  <= s9_tx_q;
      s10_ty_q  <= s9_ty_q;
    end
  end

  // ---------------------------------------------------------------- stage 11: r6
  logic signed [33:0] sh_r6;
  logic signed [31:0] s11_r6_q;
  logic signed [39:0] s11_k1t_q, s11_k2t_q;
  logic signed [31:0] s11_x_q, s11_y_q, s11_xy_q, s11_tx_q, s11_ty_q;

  assign sh_r6 = s10_r6p_q[63:30];

  always_ff @(posedge clk_i) begin
    if (adv[11]) begin
      s11_r6_q  <= ldpm_pkg::sat_q30(66'(sh_r6));
      s11_k1t_q <= s10_k1t_q;
      s11_k2t_q <= s10_k2t_q;
      s11_x_q   <= s10_x_q;
      s11_y_q   <= s10_y_q;
      s11_xy_q  <= s10_xy_q;
      s11_tx_q  <= s10_tx_q;
      s11_ty_q  <= s10_ty_q;
    end
  end

  // ---------------------------------------------------------------- stage 12: k3 term
  logic signed [63:0] k3r6_p;
  logic signed [39:0] s12_k1t_q, s12_k2t_q, s12_k3t_q;
  logic signed [31:0] s12_x_q, s12_y_q, s12_xy_q, s12_tx_q, s12_ty_q;

  assign k3r6_p = k3_q * s11_r6_q;

  always_ff @(posedge clk_i) begin
    if (adv[12]) begin
      s12_k3t_q <= k3r6_p[63:24];
      s12_k1t_q <= s11_k1t_q;
      s12_k2t_q <= s11_k2t_q;
      s12_x_q   <= s11_x_q;
      s12_y_q   <= s11_y_q;
      s12_xy_q  <= s11_xy_q;
      s12_tx_q  <= s11_tx_q;
      s12_ty_q  <= s11_ty_q;
    end
  end

  // ---------------------------------------------------------------- stage 13: radial factor
  logic signed [31:0] s13_rad_q;
  logic signed [31:0] s13_x_q, s13_y_q, s13_xy_q, s13_tx_q, s13_ty_q;

  always_ff @(posedge clk_i) begin
    if (adv[13]) begin
      s13_rad_q <= ldpm_pkg::sat_q30(ldpm_pkg::Q30One + 66'(s12_k1t_q)
                                     + 66'(s12_k2t_q) + 66'(s12_k3t_q));
      s13_x_q   <= s12_x_q;
      s13_y_q   <= s12_y_q;
      s13_xy_q  <= s12_xy_q;
      s13_tx_q  <= s12_tx_q;
      s13_ty_q  <= s12_ty_q;
    end
  end

  // ---------------------------------------------------------------- stage 14: radial and tangential products
  logic signed [63:0] p1xy_p, p2tx_p, p1ty_p, p2xy_p;
  logic signed [63:0] s14_xr_q, s14_yr_q;
  logic signed [39:0] s14_p1xy_q, s14_p2tx_q, s14_p1ty_q, s14_p2xy_q;

  assign p1xy_p = p1_q * s13_xy_q;
  assign p2tx_p = p2_q * s13_tx_q;
  assign p1ty_p = p1_q * s13_ty_q;
  assign p2xy_p = p2_q * s13_xy_q;

  always_ff @(posedge clk_i) begin
    if (adv[14]) begin
      s14_xr_q   <= s13_x_q * s13_rad_q;
      s14_yr_q   <= s13_y_q * s13_rad_q;
      s14_p1xy_q <= p1xy_p[63:24];
      s14_p2tx_q <= p2tx_p[63:24];
      s14_p1ty_q <= p1ty_p[63:24];
      s14_p2xy_q <= p2xy_p[63:24];
    end
  end

  // ---------------------------------------------------------------- stage 15: distorted xd, yd
  logic signed [33:0] sh_xr, sh_yr;
  logic signed [31:0] xr, yr;
  logic signed [31:0] s15_xd_q, s15_yd_q;

  assign sh_xr = s14_xr_q[63:30];
  assign sh_yr = s14_yr_q[63:30];
  assign xr    = ldpm_pkg::sat_q30(66'(sh_xr));
  assign yr    = ldpm_pkg::sat_q30(66'(sh_yr));

  always_ff @(posedge clk_i) begin
    if (adv[15]) begin
      s15_xd_q <= ldpm_pkg::sat_q30(66'(xr) + (66'(s14_p1xy_q) <<< 1) + 66'(s14_p2tx_q));
      s15_yd_q <= ldpm_pkg::sat_q30(66'(yr) + 66'(s14_p1ty_q) + (66'(s14_p2xy_q) <<< 1));
    end
  end

  // ---------------------------------------------------------------- stage 16: scale back
  logic signed [16:0] fxs, fys;
  logic signed [48:0] s16_xf_q, s16_yf_q;

  assign fxs = $signed({1'b0, fx});
  assign fys = $signed({1'b0, fy});

  always_ff @(posedge clk_i) begin
    if (adv[16]) begin
      s16_xf_q <= s15_xd_q * fxs;
      s16_yf_q <= s15_yd_q * fys;
    end
  end

  // ---------------------------------------------------------------- stage 17: offset, clamp, output word
  logic [19:0] rx, ry;
  logic        lo_x, hi_x, lo_y, hi_y;
  logic [15:0] mx_q, my_q;
  logic        clip_q;

  assign rx   = {s16_xf_q[48], s16_xf_q[48:30]} + {4'b0000, cx};
  assign ry   = {s16_yf_q[48], s16_yf_q[48:30]} + {4'b0000, cy};
  assign lo_x = rx[19];
  assign hi_x = !rx[19] && (rx[18:16] != 3'b000);
  assign lo_y = ry[19];
  assign hi_y = !ry[19] && (ry[18:16] != 3'b000);

  always_ff @(posedge clk_i) begin
    if (adv[Last]) begin
      mx_q   <= lo_x ? 16'h0000 : (hi_x ? 16'hffff : rx[15:0]);
      my_q   <= lo_y ? 16'h0000 : (hi_y ? 16'hffff : ry[15:0]);
      clip_q <= lo_x || hi_x || lo_y || hi_y;
    end
  end

  assign m_axis_tvalid = vld_q[Last];
  assign m_axis_tdata  = {my_q, mx_q};
  assign m_axis_tuser  = clip_q;

  // ---------------------------------------------------------------- checks
  // an empty output stage means every stage can move, so the input is open
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked while output stage is empty");

  // the pipeline gains at most one word per cycle
  a_fill_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ($countones(vld_q) <= $past($countones(vld_q)) + 1))
    else $error("pipeline occupancy grew by more than one word");

  // a clipped word sits on a range bound
  a_clip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (mx_q == 16'h0000 || mx_q == 16'hffff || my_q == 16'h0000 || my_q == 16'hffff))
    else $error("clip flag set on an in-range point");

endmodule

`default_nettype wire

/* sim/lens_distortion_point_map_test.sv */
`default_nettype none

module lens_distortion_point_map_test;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic        clip;
  } mapped_point_t;

  // Predicts distorted points from the current coefficients and holds them in order
  class distortion_scoreboard;
    logic [31:0]   principal;
    logic [15:0]   focal_x;
    logic [15:0]   focal_y;
    longint        k1, k2, k3, p1, p2;
    mapped_point_t pending[$];
    int            errors;

    function new();
      principal = ldpm_pkg::PrincipalRst;
      focal_x   = ldpm_pkg::FocalRst;
      focal_y   = ldpm_pkg::FocalRst;
      k1 = 0; k2 = 0; k3 = 0; p1 = 0; p2 = 0;
      errors = 0;
    endfunction

    function void write_reg(ldpm_pkg::ldpm_reg_e idx, logic [31:0] v);
      case (idx)
        ldpm_pkg::RegPrincipal: principal = v;
        ldpm_pkg::RegFocalX:    focal_x = v[15:0];
        ldpm_pkg::RegFocalY:    focal_y = v[15:0];
        ldpm_pkg::RegK1:        k1 = longint'($signed(v));
        ldpm_pkg::RegK2:        k2 = longint'($signed(v));
        ldpm_pkg::RegK3:        k3 = longint'($signed(v));
        ldpm_pkg::RegP1:        p1 = longint'($signed(v));
        ldpm_pkg::RegP2:        p2 = longint'($signed(v));
        default: ;
      endcase
    endfunction

    // Clamp to Q2.30
    function longint clamp(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Back to Q12.4 pixels, saturating and flagging
    function logic [15:0] to_pixels(longint v, longint f, longint c, inout logic clip);
      longint r;
      r = ((v * f) >>> 30) + c;
      if (r < 0) begin
        clip = 1'b1;
        return 16'd0;
      end
      if (r > 65535) begin
        clip = 1'b1;
        return 16'hffff;
      end
      return r[15:0];
    endfunction

    function void note(logic [15:0] px, logic [15:0] py);
      longint cx, cy, fx, fy, x, y, x2, y2, xy, r2, r4, r6, rad, xd, yd, tx, ty;
      mapped_point_t m;
      cx = principal[31:16];
      cy = principal[15:0];
      fx = (focal_x == 0) ? 1 : focal_x;
      fy = (focal_y == 0) ? 1 : focal_y;
      x  = clamp(((longint'(px) - cx) * 64'sd1073741824) / fx);
      y  = clamp(((longint'(py) - cy) * 64'sd1073741824) / fy);
      x2 = clamp((x * x) >>> 30);
      y2 = clamp((y * y) >>> 30);
      xy = clamp((x * y) >>> 30);
      r2 = clamp(x2 + y2);
      r4 = clamp((r2 * r2) >>> 30);
      r6 = clamp((r4 * r2) >>> 30);
      rad = clamp(64'sd1073741824 + ((k1 * r2) >>> 24) + ((k2 * r4) >>> 24)
                  + ((k3 * r6) >>> 24));
      xd = clamp((x * rad) >>> 30);
      yd = clamp((y * rad) >>> 30);
      tx = clamp(r2 + 2 * x2);
      ty = clamp(r2 + 2 * y2);
      xd = clamp(xd + 2 * ((p1 * xy) >>> 24) + ((p2 * tx) >>> 24));
      yd = clamp(yd + ((p1 * ty) >>> 24) + 2 * ((p2 * xy) >>> 24));
      m.clip = 1'b0;
      m.x = to_pixels(xd, fx, cx, m.clip);
      m.y = to_pixels(yd, fy, cy, m.clip);
      pending = {pending, m};
    endfunction

    function void check(logic [15:0] mx, logic [15:0] my, logic clip);
      mapped_point_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word x=%h y=%h clip=%b", $time, mx, my, clip);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.x !== mx) begin
        $display("%0t: mapped_x expected %h actual %h", $time, e.x, mx);
        errors++;
      end
      if (e.y !== my) begin
        $display("%0t: mapped_y expected %h actual %h", $time, e.y, my);
        errors++;
      end
      if (e.clip !== clip) begin
        $display("%0t: clipped expected %b actual %b", $time, e.clip, clip);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  distortion_scoreboard points = new();
  bit          calm;
  int unsigned cycles;
  localparam int unsigned CycleLimit = 200000;

  lens_distortion_point_map DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Stall the output side at random unless in a calm stretch
  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 12);
  end

  // Check every accepted word and watch the cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      points.check(m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser);
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Write one register; caller sits at a falling edge with nothing in flight
  task automatic write_reg(ldpm_pkg::ldpm_reg_e idx, logic [31:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    points.write_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] pp, logic [15:0] fx, logic [15:0] fy,
                           logic [31:0] c1, logic [31:0] c2, logic [31:0] c3,
                           logic [31:0] t1, logic [31:0] t2);
    write_reg(ldpm_pkg::RegPrincipal, pp);
    write_reg(ldpm_pkg::RegFocalX, {16'd0, fx});
    write_reg(ldpm_pkg::RegFocalY, {16'd0, fy});
    write_reg(ldpm_pkg::RegK1, c1);
    write_reg(ldpm_pkg::RegK2, c2);
    write_reg(ldpm_pkg::RegK3, c3);
    write_reg(ldpm_pkg::RegP1, t1);
    write_reg(ldpm_pkg::RegP2, t2);
  endtask

  // Offer one point, with random idle cycles ahead of it outside a calm stretch
  task automatic send_point(logic [15:0] px, logic [15:0] py);
    while (!calm && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {py, px};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    points.note(px, py);
    @(negedge clk_i);
  endtask

  // Hold until every expected word has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (points.pending.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Signed coefficient of modest size
  function automatic logic [31:0] small_coef(int unsigned bits);
    return 32'($signed($urandom_range((1 << bits) - 1)) - $signed(1 << (bits - 1)));
  endfunction

  task automatic run_phase(int n);
    logic [15:0] cx, cy;
    cx = points.principal[31:16];
    cy = points.principal[15:0];
    send_point(16'd0, 16'd0);
    send_point(16'hffff, 16'hffff);
    send_point(16'd0, 16'hffff);
    send_point(16'hffff, 16'd0);
    send_point(cx, cy);
    send_point(cx + 16'd1, cy - 16'd1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0)
        send_point(16'($urandom), 16'($urandom));
      else
        send_point(cx + 16'($signed($urandom_range(4095)) - 2048),
                   cy + 16'($signed($urandom_range(4095)) - 2048));
    end
    drain();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = ldpm_pkg::RegPrincipal;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cycles        = 0;
    calm          = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset values, zero coefficients: identity map where the normalization does not saturate
    run_phase(60);

    // Typical camera with mild distortion of random sign, no idling
    calm = 1'b1;
    write_all({16'd5120, 16'd3840}, 16'd8000, 16'd8000, small_coef(23), small_coef(21),
              small_coef(19), small_coef(18), small_coef(18));
    run_phase(120);
    calm = 1'b0;

    // Zero focal lengths, centered principal point
    write_all(32'h8000_8000, 16'd0, 16'd0, 32'h0100_0000, 32'd0, 32'd0, 32'd0, 32'd0);
    run_phase(60);

    // Largest principal point and focal lengths, positive extreme coefficients
    write_all(32'hffff_ffff, 16'hffff, 16'hffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    run_phase(60);

    // Negative extreme coefficients
    write_all(32'h4000_2000, 16'd1, 16'd2, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    run_phase(60);

    // Random settings, some realistic and some raw
    for (int ph = 0; ph < 6; ph++) begin
      if (ph[0])
        write_all($urandom, 16'($urandom), 16'($urandom), $urandom, $urandom,
                  $urandom, $urandom, $urandom);
      else
        write_all({16'($urandom_range(12000, 2000)), 16'($urandom_range(9000, 1500))},
                  16'($urandom_range(20000, 2000)), 16'($urandom_range(20000, 2000)),
                  small_coef(24), small_coef(22), small_coef(20), small_coef(19),
                  small_coef(19));
      run_phase(60);
    end

    repeat (40) @(negedge clk_i);
    if (points.errors == 0 && points.pending.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
